/* rtl/cbd_pkg.sv */
// Shared types and constants for the chunked body decoder.
// No dependencies; every other RTL file takes names from here by scope.
`default_nettype none

package cbd_pkg;

	// Default width of the chunk size counters
	localparam int unsigned SIZE_BITS_DEF = 32;

	// Item field widths
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KIND_W = 2;

	// Characters of interest on the line side
	localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;

	// Decoder phase
	typedef enum logic [1:0] {
		PH_LINE = 2'd0,
		PH_DATA = 2'd1,
		PH_DONE = 2'd2,
		PH_ERR  = 2'd3
	} phase_t;

	// Result kind codes
	typedef enum logic [KIND_W-1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	// Result item handed from the decode core to the output register
	typedef struct packed {
		logic              vld;
		logic [BYTE_W-1:0] data;
		kind_t             kind;
		logic              last;
	} res_t;

endpackage

`default_nettype wire

/* rtl/cbd_in_reg.sv */
// Input register stage of the chunked body decoder.
// Depends on cbd_pkg for the byte width.
`default_nettype none

module cbd_in_reg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      src_valid,
	output logic                           src_stall,
	input  wire logic [cbd_pkg::BYTE_W-1:0] byte_in,
	input  wire logic                      advance,
	output logic                           valid_s1,
	output logic [cbd_pkg::BYTE_W-1:0]     byte_s1
);

	logic accept;

	// Hold off the source only while the staged item cannot move on
	assign src_stall = valid_s1 & ~advance;
	assign accept    = src_valid & ~src_stall;

	// Stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= byte_in;
		end
	end

	// Assertions
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> valid_s1)
		else $error("source stalled with empty input stage");
	a_adv_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> valid_s1)
		else $error("advance with empty input stage");
	a_hold_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("staged item lost while held");

endmodule

`default_nettype wire

/* rtl/cbd_core.sv */
// Decode core: phase machine, hex size build and chunk byte counting.
// Depends on cbd_pkg for phase, kind and result types.
`default_nettype none

module cbd_core #(
	parameter int unsigned SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      go,
	input  wire logic [cbd_pkg::BYTE_W-1:0] ch,
	output cbd_pkg::res_t                  res
);

	cbd_pkg::phase_t phase_q, phase_d;
	logic [SIZE_BITS-1:0] len_q, len_d;
	logic [SIZE_BITS-1:0] taken_q, taken_d;
	logic [SIZE_BITS-1:0] acc_q, acc_d;
	logic stopped_q, stopped_d;
	logic content_q, content_d;
	logic pcr_q, pcr_d;

	logic [SIZE_BITS-1:0] taken_inc;
	logic                 last_byte;
	logic [4:0]           hex;
	logic                 is_nul, is_lf, is_cr;

	// {is_hex, value} of an ASCII character
	function automatic logic [4:0] hex_of(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	assign hex       = hex_of(ch);
	assign is_nul    = (ch == cbd_pkg::CH_NUL);
	assign is_lf     = (ch == cbd_pkg::CH_LF);
	assign is_cr     = (ch == cbd_pkg::CH_CR);
	assign taken_inc = taken_q + {{(SIZE_BITS-1){1'b0}}, 1'b1};
	assign last_byte = (taken_inc == len_q);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (go) begin
			case (phase_q)
				cbd_pkg::PH_LINE: begin
					if (is_nul) begin
						phase_d = cbd_pkg::PH_ERR;
					end else if (is_lf && content_q) begin
						phase_d = (acc_q == '0) ? cbd_pkg::PH_DONE : cbd_pkg::PH_DATA;
					end
				end
				cbd_pkg::PH_DATA: begin
					if (last_byte) begin
						phase_d = cbd_pkg::PH_LINE;
					end
				end
				cbd_pkg::PH_DONE: phase_d = cbd_pkg::PH_DONE;
				cbd_pkg::PH_ERR:  phase_d = cbd_pkg::PH_ERR;
				default:          phase_d = phase_q;
			endcase
		end
	end

	// Result item for the current byte
	always_comb begin
		res      = '0;
		res.kind = cbd_pkg::KIND_DATA;
		if (go) begin
			case (phase_q)
				cbd_pkg::PH_LINE: begin
					if (is_nul) begin
						res.vld  = 1'b1;
						res.kind = cbd_pkg::KIND_ERR;
					end else if (is_lf && content_q && acc_q == '0) begin
						res.vld  = 1'b1;
						res.kind = cbd_pkg::KIND_END;
					end
				end
				cbd_pkg::PH_DATA: begin
					res.vld  = 1'b1;
					res.data = ch;
					res.last = last_byte;
				end
				cbd_pkg::PH_ERR: begin
					res.vld  = 1'b1;
					res.kind = cbd_pkg::KIND_ERR;
				end
				cbd_pkg::PH_DONE: res.vld = 1'b0;
				default:          res.vld = 1'b0;
			endcase
		end
	end

	// Line parser and chunk counters
	always_comb begin
		len_d     = len_q;
		taken_d   = taken_q;
		acc_d     = acc_q;
		stopped_d = stopped_q;
		content_d = content_q;
		pcr_d     = pcr_q;
		if (go && phase_q == cbd_pkg::PH_DATA) begin
			taken_d = taken_inc;
		end else if (go && phase_q == cbd_pkg::PH_LINE && !is_nul) begin
			if (is_lf) begin
				// end of line: latch size (or clear on an empty line)
				len_d     = content_q ? acc_q : '0;
				taken_d   = '0;
				acc_d     = '0;
				stopped_d = 1'b0;
				content_d = 1'b0;
				pcr_d     = 1'b0;
			end else begin
				if (!stopped_q) begin
					if (hex[4]) begin
						acc_d = {acc_q[SIZE_BITS-5:0], hex[3:0]};
					end else begin
						stopped_d = 1'b1;
					end
				end
				// a CR only counts as content once something follows it
				content_d = content_q | pcr_q | ~is_cr;
				pcr_d     = is_cr;
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= cbd_pkg::PH_LINE;
			len_q     <= '0;
			taken_q   <= '0;
			acc_q     <= '0;
			stopped_q <= 1'b0;
			content_q <= 1'b0;
			pcr_q     <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			len_q     <= len_d;
			taken_q   <= taken_d;
			acc_q     <= acc_d;
			stopped_q <= stopped_d;
			content_q <= content_d;
			pcr_q     <= pcr_d;
		end
	end

	// Assertions
	a_err_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == cbd_pkg::PH_ERR |=> phase_q == cbd_pkg::PH_ERR)
		else $error("left error phase");
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == cbd_pkg::PH_DONE |-> !res.vld)
		else $error("result after end of body");
	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == cbd_pkg::PH_DATA |-> len_q != '0)
		else $error("data phase with zero chunk length");

endmodule

`default_nettype wire

/* rtl/cbd_out_reg.sv */
// Result register of the chunked body decoder.
// Depends on cbd_pkg for the result item type.
`default_nettype none

module cbd_out_reg (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  pending,
	input  wire cbd_pkg::res_t         res,
	output logic                       advance,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output logic [cbd_pkg::BYTE_W-1:0] byte_out,
	output logic [cbd_pkg::KIND_W-1:0] kind,
	output logic                       chunk_end
);

	logic load;

	// The staged item moves on when the result slot is free or draining
	assign advance = pending & (~res_valid | ~res_stall);
	assign load    = advance & res.vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else begin
			res_valid <= load | (res_valid & res_stall);
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			byte_out  <= res.data;
			kind      <= cbd_pkg::KIND_W'(res.kind);
			chunk_end <= res.last;
		end
	end

	// Assertions
	a_end_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && chunk_end) |-> kind == cbd_pkg::KIND_DATA)
		else $error("chunk end marked on a non-payload item");
	a_non_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && kind != cbd_pkg::KIND_DATA) |-> byte_out == '0)
		else $error("non-payload item carries a byte");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |-> !load)
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire

/* rtl/chunked_body_decoder_unit.sv */
// Top level of the chunked body decoder: input stage, decode core, result register.
// Depends on cbd_pkg, cbd_in_reg, cbd_core and cbd_out_reg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  src     | in        | src_valid/src_stall  | byte_in[7:0]
//  res     | out       | res_valid/res_stall  | byte_out[7:0], kind[1:0], chunk_end
//
// One byte per cycle while no stall holds the flow; a byte is registered in the input
// stage and then its result in the result register.
// Each byte is decoded from the input stage once it can advance; the
// decode core updates its state in the same cycle as the result register loads.
// Size-line bytes give no result item but a NUL (error) or the zero-size line's LF (end); none after end of body.
// arst_n clears phase, counters and both stage valid flags.
// A stall on res holds the result; the input stage can still take one more item if it is empty.
`default_nettype none

module chunked_body_decoder_unit #(
	parameter int unsigned SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      src_valid,
	output logic                           src_stall,
	input  wire logic [cbd_pkg::BYTE_W-1:0] byte_in,
	output logic                           res_valid,
	input  wire logic                      res_stall,
	output logic [cbd_pkg::BYTE_W-1:0]     byte_out,
	output logic [cbd_pkg::KIND_W-1:0]     kind,
	output logic                           chunk_end
);

	logic                      valid_s1;
	logic [cbd_pkg::BYTE_W-1:0] byte_s1;
	logic                      advance;
	cbd_pkg::res_t             res;

	cbd_in_reg u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.byte_in   (byte_in),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1)
	);

	cbd_core #(
		.SIZE_BITS (SIZE_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (advance),
		.ch     (byte_s1),
		.res    (res)
	);

	cbd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.pending   (valid_s1),
		.res       (res),
		.advance   (advance),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.byte_out  (byte_out),
		.kind      (kind),
		.chunk_end (chunk_end)
	);

endmodule

`default_nettype wire
